// ===== sv/capture_tachometer_median_defines.svh =====
// Assertion macros shared by the tachometer modules.
`ifndef CAPTURE_TACHOMETER_MEDIAN_DEFINES_SVH
`define CAPTURE_TACHOMETER_MEDIAN_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctm: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctm: next-cycle check failed");

`endif

// ===== sv/ctm_pkg.sv =====
package ctm_pkg;

    // Median window
    localparam int WINDOW_LEN = 7;
    localparam int MED_IDX    = WINDOW_LEN / 2;
    localparam int WCNT_W     = $clog2(WINDOW_LEN + 1);

    // Field widths
    localparam int CNT_W   = 32;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 32;
    localparam int DIR_W   = 2;
    localparam int CLK_W   = 27;
    localparam int PPR_W   = 16;
    localparam int TMO_W   = 16;

    // Divider: numerator is 60 * clock, denominator is delta * pulses
    localparam int NUM_W     = CLK_W + 6;
    localparam int DEN_W     = CNT_W + PPR_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = CLK_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = CFG_IDX_W'(3);

    localparam logic [CLK_W-1:0] RST_CLOCK_HZ   = CLK_W'(80000000);
    localparam logic [PPR_W-1:0] RST_PULSES     = PPR_W'(400);
    localparam logic [TMO_W-1:0] RST_TIMEOUT_MS = TMO_W'(100);

    // Opcodes
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    // Direction codes
    localparam logic signed [DIR_W-1:0] DIR_NONE  = 2'sb00;
    localparam logic signed [DIR_W-1:0] DIR_PLUS  = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_MINUS = 2'sb11;

    localparam logic [SPEED_W-2:0] SPEED_MAX = {(SPEED_W-1){1'b1}};

    typedef struct packed {
        logic accept_cap;
        logic accept_query;
        logic check;
        logic div_step;
        logic finish_div;
        logic push;
        logic rank;
        logic load_out;
    } t_ctm_cmd;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_ctm_sts;

endpackage

// ===== sv/ctm_if.sv =====
interface ctm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [ctm_pkg::CNT_W-1:0]    capture_count;
    logic                         phase_b;
    logic [ctm_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, opcode, capture_count, phase_b, time_ms, input ready);
    modport sink   (input valid, opcode, capture_count, phase_b, time_ms, output ready);
endinterface

interface ctm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctm_pkg::SPEED_W-1:0]  speed_rpm;
    logic signed [ctm_pkg::DIR_W-1:0]    rotation_dir;

    modport source (output valid, speed_rpm, rotation_dir, input ready);
    modport sink   (input valid, speed_rpm, rotation_dir, output ready);
endinterface

interface ctm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ctm_pkg::CFG_IDX_W-1:0]     index;
    logic [ctm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ctm_datapath.sv =====
`include "capture_tachometer_median_defines.svh"

module ctm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ctm_pkg::t_ctm_cmd                   i_cmd,
    output ctm_pkg::t_ctm_sts                   o_sts,
    input  logic                                i_cfg_valid,
    input  logic [ctm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ctm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [ctm_pkg::CNT_W-1:0]           i_in_count,
    input  logic                                i_in_phase_b,
    input  logic [ctm_pkg::TIME_W-1:0]          i_in_time,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [ctm_pkg::SPEED_W-1:0]  o_out_speed,
    output logic signed [ctm_pkg::DIR_W-1:0]    o_out_dir
);

    // Configuration
    logic [ctm_pkg::CLK_W-1:0] r_clock_hz;
    logic [ctm_pkg::PPR_W-1:0] r_pulses;
    logic [ctm_pkg::TMO_W-1:0] r_timeout;
    logic                      r_reverse;

    // Capture state
    logic [ctm_pkg::CNT_W-1:0]          r_cur_cap;
    logic [ctm_pkg::CNT_W-1:0]          r_prev_cap;
    logic [ctm_pkg::TIME_W-1:0]         r_cap_time;
    logic signed [ctm_pkg::DIR_W-1:0]   r_dir;
    logic signed [ctm_pkg::SPEED_W-1:0] r_held;
    logic [ctm_pkg::TIME_W-1:0]         r_now;

    // Divider
    logic [ctm_pkg::DEN_W-1:0] r_den;
    logic [ctm_pkg::DEN_W:0]   r_rem;
    logic [ctm_pkg::NUM_W-1:0] r_quo;

    // Median window
    logic signed [ctm_pkg::SPEED_W-1:0] r_win [ctm_pkg::WINDOW_LEN];
    logic signed [ctm_pkg::SPEED_W-1:0] r_feed;
    logic signed [ctm_pkg::SPEED_W-1:0] r_med;
    logic                               r_found;

    // Output register
    logic                               r_out_valid;
    logic signed [ctm_pkg::SPEED_W-1:0] r_out_speed;
    logic signed [ctm_pkg::DIR_W-1:0]   r_out_dir;

    logic [ctm_pkg::TIME_W-1:0]         age;
    logic                               stale;
    logic [ctm_pkg::CNT_W-1:0]          delta;
    logic                               delta_zero;
    logic [ctm_pkg::NUM_W-1:0]          num;
    logic [ctm_pkg::DEN_W:0]            trial;
    logic                               fits;
    logic [ctm_pkg::SPEED_W-2:0]        mag;
    logic signed [ctm_pkg::SPEED_W-1:0] signed_speed;
    logic [ctm_pkg::WCNT_W-1:0]         n_less;
    logic [ctm_pkg::WCNT_W-1:0]         n_leq;
    logic                               rank_hit;

    assign age        = r_now - r_cap_time;
    assign stale      = age > ctm_pkg::TIME_W'(r_timeout);
    assign delta      = r_cur_cap - r_prev_cap;
    assign delta_zero = (delta == '0);

    // 60 * clock as two shifts
    assign num = {r_clock_hz, 6'b0} - {4'b0, r_clock_hz, 2'b0};

    assign trial = {r_rem[ctm_pkg::DEN_W-1:0], r_quo[ctm_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    assign mag = (r_quo > ctm_pkg::NUM_W'(ctm_pkg::SPEED_MAX))
                 ? ctm_pkg::SPEED_MAX : r_quo[ctm_pkg::SPEED_W-2:0];

    always_comb begin
        if (r_dir == ctm_pkg::DIR_NONE) begin
            signed_speed = '0;
        end else if (r_dir[ctm_pkg::DIR_W-1]) begin
            signed_speed = -$signed({1'b0, mag});
        end else begin
            signed_speed = $signed({1'b0, mag});
        end
    end

    // Rank of the head entry against the whole window
    always_comb begin
        n_less = '0;
        n_leq  = '0;
        for (int j = 0; j < ctm_pkg::WINDOW_LEN; j++) begin
            n_less = n_less + ctm_pkg::WCNT_W'(r_win[j] <  r_win[0]);
            n_leq  = n_leq  + ctm_pkg::WCNT_W'(r_win[j] <= r_win[0]);
        end
        rank_hit = (n_less <= ctm_pkg::WCNT_W'(ctm_pkg::MED_IDX))
                && (n_leq  >  ctm_pkg::WCNT_W'(ctm_pkg::MED_IDX));
    end

    assign o_sts.need_div = !stale && !delta_zero;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ctm_pkg::RST_CLOCK_HZ;
            r_pulses   <= ctm_pkg::RST_PULSES;
            r_timeout  <= ctm_pkg::RST_TIMEOUT_MS;
            r_reverse  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ctm_pkg::CFG_CLOCK_HZ:   r_clock_hz <= i_cfg_data[ctm_pkg::CLK_W-1:0];
                ctm_pkg::CFG_PULSES:     r_pulses   <= i_cfg_data[ctm_pkg::PPR_W-1:0];
                ctm_pkg::CFG_TIMEOUT_MS: r_timeout  <= i_cfg_data[ctm_pkg::TMO_W-1:0];
                ctm_pkg::CFG_REVERSE:    r_reverse  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cap  <= '0;
            r_prev_cap <= '0;
            r_cap_time <= '0;
            r_dir      <= ctm_pkg::DIR_NONE;
            r_held     <= '0;
        end else begin
            if (i_cmd.accept_cap) begin
                r_prev_cap <= r_cur_cap;
                r_cur_cap  <= i_in_count;
                r_cap_time <= i_in_time;
                r_dir      <= (r_reverse ^ i_in_phase_b) ? ctm_pkg::DIR_MINUS : ctm_pkg::DIR_PLUS;
            end
            if (i_cmd.finish_div) begin
                r_held <= signed_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_query) begin
            r_now <= i_in_time;
        end
        if (i_cmd.check) begin
            r_den <= r_pulses * delta;
            r_rem <= '0;
            r_quo <= num;
            r_feed <= stale ? '0 : r_held;
        end else if (i_cmd.div_step) begin
            // One restoring step: a zero divisor yields all ones and saturates
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[ctm_pkg::NUM_W-2:0], fits};
        end else if (i_cmd.finish_div) begin
            r_feed <= signed_speed;
        end
        if (i_cmd.rank && rank_hit) begin
            r_med <= r_win[0];
        end
    end

    // Push the newest value, then rotate once per entry so the window comes back unchanged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ctm_pkg::WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_found <= 1'b0;
        end else if (i_cmd.push) begin
            r_win[0] <= r_feed;
            for (int k = 1; k < ctm_pkg::WINDOW_LEN; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_found <= 1'b0;
        end else if (i_cmd.rank) begin
            for (int k = 0; k < ctm_pkg::WINDOW_LEN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[ctm_pkg::WINDOW_LEN-1] <= r_win[0];
            if (rank_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_speed <= r_med;
            r_out_dir   <= r_dir;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_speed = r_out_speed;
    assign o_out_dir   = r_out_dir;

    `CTM_ASSERT_IMP(a_load_into_free_slot, i_clk, i_rst_n, i_cmd.load_out, !r_out_valid || i_out_ready)
    `CTM_ASSERT_IMP(a_median_found, i_clk, i_rst_n, i_cmd.load_out, r_found)

endmodule

// ===== sv/ctm_ctrl.sv =====
`include "capture_tachometer_median_defines.svh"

module ctm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_opcode,
    output logic              o_in_ready,
    input  ctm_pkg::t_ctm_sts i_sts,
    output ctm_pkg::t_ctm_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_SIGN  = 7'b0001000,
        S_PUSH  = 7'b0010000,
        S_RANK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [ctm_pkg::STEP_W-1:0] r_cnt;
    logic [ctm_pkg::STEP_W-1:0] n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_opcode == ctm_pkg::OP_QUERY) begin
                        o_cmd.accept_query = 1'b1;
                        n_state            = S_CHECK;
                    end else begin
                        o_cmd.accept_cap = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = '0;
                n_state     = i_sts.need_div ? S_DIV : S_PUSH;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == ctm_pkg::STEP_W'(ctm_pkg::DIV_STEPS - 1)) begin
                    n_state = S_SIGN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SIGN: begin
                o_cmd.finish_div = 1'b1;
                n_state          = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_cnt      = '0;
                n_state    = S_RANK;
            end
            S_RANK: begin
                o_cmd.rank = 1'b1;
                if (r_cnt == ctm_pkg::STEP_W'(ctm_pkg::WINDOW_LEN - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // hold the median until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `CTM_ASSERT_NXT(a_rank_exits_to_done, i_clk, i_rst_n, r_state == S_RANK, r_state == S_RANK || r_state == S_DONE)

endmodule

// ===== sv/capture_tachometer_median.sv =====
// Period-capture tachometer with a median filter. A capture word (opcode 0) updates the
// stored counts, capture time and direction and is taken while the block stays idle; it gives no result.
// A speed query (opcode 1) gives one result word and keeps the input side busy from its
// check state through the push, rank and done states, and through the divide and sign
// states as well when a new speed is worked out rather than held or stale. The divider
// takes its 33 restoring steps at one bit a cycle, and the median pass ranks one window
// entry per cycle. The result sits in an output register, so the next word is taken while
// it waits; a query only stalls at its end if the previous result has not been taken.
// Configuration writes are always taken and must come while idle.
module capture_tachometer_median (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ctm_in_if.sink  i_in,
    ctm_out_if.source o_out,
    ctm_cfg_if.sink i_cfg
);

    ctm_pkg::t_ctm_cmd cmd;
    ctm_pkg::t_ctm_sts sts;

    assign i_cfg.ready = 1'b1;

    ctm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ctm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_in_count   (i_in.capture_count),
        .i_in_phase_b (i_in.phase_b),
        .i_in_time    (i_in.time_ms),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_speed  (o_out.speed_rpm),
        .o_out_dir    (o_out.rotation_dir)
    );

endmodule
